// ===== hw/rtl/etbt_pkg.sv =====
// ----------------------------------------------------------------------------
// etbt_pkg: shared types and constants of the elapsed time block
// field widths, microcode control word, step addresses and calendar tables
// ----------------------------------------------------------------------------
`default_nettype none

package etbt_pkg;

  // timestamp field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // result field widths
  localparam int EDAYS_W = 22;
  localparam int EHOUR_W = 5;
  localparam int EMIN_W  = 6;
  localparam int ESEC_W  = 6;

  // datapath widths
  localparam int DD_W    = 25;  // signed day difference
  localparam int SD_W    = 19;  // signed second-of-day difference
  localparam int REST_W  = 17;  // seconds within one day
  localparam int X_W     = 15;  // shifted year for the century terms
  localparam int Q_W     = 8;   // quotient by 100, 400 or 60
  localparam int DIV_W   = 9;
  localparam int MUL_A_W = 17;
  localparam int MUL_K_W = 14;
  localparam int PROD_W  = MUL_A_W + MUL_K_W;
  localparam int PC_W    = 4;
  localparam int CUM_W   = 9;

  // reciprocals, each rounded down, so an estimate is exact or one low
  localparam logic [MUL_K_W-1:0] RECIP_CENT   = MUL_K_W'(10485);
  localparam int                 SH_100       = 20;
  localparam int                 SH_400       = 22;
  localparam logic [MUL_K_W-1:0] RECIP_HOUR   = MUL_K_W'(1165);
  localparam int                 SH_HOUR      = 22;
  localparam logic [MUL_K_W-1:0] RECIP_MINUTE = MUL_K_W'(1092);
  localparam int                 SH_MINUTE    = 16;

  localparam logic signed [SD_W-1:0] SECS_DAY  = SD_W'(86400);
  localparam logic signed [SD_W-1:0] SECS_HOUR = SD_W'(3600);
  localparam logic signed [DD_W-1:0] DAYS_MAX  = DD_W'(4194303);

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } stamp_t;

  typedef struct packed {
    logic [EDAYS_W-1:0] days;
    logic [EHOUR_W-1:0] hours;
    logic [EMIN_W-1:0]  minutes;
    logic [ESEC_W-1:0]  seconds;
    logic               end_before_start;
  } res_t;

  typedef enum logic [3:0] {
    OP_YEAR,
    OP_Q100,
    OP_FIX100,
    OP_Q400,
    OP_FIX400,
    OP_MONTH,
    OP_NORM_LO,
    OP_NORM_HI,
    OP_HQ,
    OP_HFIX,
    OP_MQ,
    OP_MFIX,
    OP_DONE
  } op_e;

  typedef enum logic [1:0] {
    J_NONE,
    J_SIDE0,
    J_SD_NEG,
    J_SD_HIGH
  } jmp_e;

  typedef struct packed {
    op_e             op;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic side;
    logic sd_neg;
    logic sd_high;
    logic out_full;
  } status_t;

  // step addresses of the microprogram
  localparam logic [PC_W-1:0] PC_YEAR    = PC_W'(0);
  localparam logic [PC_W-1:0] PC_Q100    = PC_W'(1);
  localparam logic [PC_W-1:0] PC_FIX100  = PC_W'(2);
  localparam logic [PC_W-1:0] PC_Q400    = PC_W'(3);
  localparam logic [PC_W-1:0] PC_FIX400  = PC_W'(4);
  localparam logic [PC_W-1:0] PC_MONTH   = PC_W'(5);
  localparam logic [PC_W-1:0] PC_NORM_LO = PC_W'(6);
  localparam logic [PC_W-1:0] PC_NORM_HI = PC_W'(7);
  localparam logic [PC_W-1:0] PC_HQ      = PC_W'(8);
  localparam logic [PC_W-1:0] PC_HFIX    = PC_W'(9);
  localparam logic [PC_W-1:0] PC_MQ      = PC_W'(10);
  localparam logic [PC_W-1:0] PC_MFIX    = PC_W'(11);
  localparam logic [PC_W-1:0] PC_DONE    = PC_W'(12);

  // days in the months before the given one; month codes outside 1..12 clamp
  function automatic logic [CUM_W-1:0] cum_days(logic [MONTH_W-1:0] m);
    logic [CUM_W-1:0] c;
    unique case (m)
      MONTH_W'(0), MONTH_W'(1): c = CUM_W'(0);
      MONTH_W'(2):  c = CUM_W'(31);
      MONTH_W'(3):  c = CUM_W'(59);
      MONTH_W'(4):  c = CUM_W'(90);
      MONTH_W'(5):  c = CUM_W'(120);
      MONTH_W'(6):  c = CUM_W'(151);
      MONTH_W'(7):  c = CUM_W'(181);
      MONTH_W'(8):  c = CUM_W'(212);
      MONTH_W'(9):  c = CUM_W'(243);
      MONTH_W'(10): c = CUM_W'(273);
      MONTH_W'(11): c = CUM_W'(304);
      default:      c = CUM_W'(334);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/etbt_if.sv =====
// ----------------------------------------------------------------------------
// etbt_if: word channels of the elapsed time block
// input channel carries two timestamps, output channel one elapsed time
// ----------------------------------------------------------------------------
`default_nettype none

interface etbt_in_if import etbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  start_year;
  logic [MONTH_W-1:0] start_month;
  logic [DAY_W-1:0]   start_day;
  logic [HOUR_W-1:0]  start_hour;
  logic [MIN_W-1:0]   start_minute;
  logic [SEC_W-1:0]   start_second;
  logic [YEAR_W-1:0]  end_year;
  logic [MONTH_W-1:0] end_month;
  logic [DAY_W-1:0]   end_day;
  logic [HOUR_W-1:0]  end_hour;
  logic [MIN_W-1:0]   end_minute;
  logic [SEC_W-1:0]   end_second;

  modport source (
    output valid, start_year, start_month, start_day, start_hour, start_minute,
           start_second, end_year, end_month, end_day, end_hour, end_minute,
           end_second,
    input  ready
  );

  modport sink (
    input  valid, start_year, start_month, start_day, start_hour, start_minute,
           start_second, end_year, end_month, end_day, end_hour, end_minute,
           end_second,
    output ready
  );
endinterface

interface etbt_out_if import etbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EDAYS_W-1:0] elapsed_days;
  logic [EHOUR_W-1:0] elapsed_hours;
  logic [EMIN_W-1:0]  elapsed_minutes;
  logic [ESEC_W-1:0]  elapsed_seconds;
  logic               end_before_start;

  modport source (
    output valid, elapsed_days, elapsed_hours, elapsed_minutes, elapsed_seconds,
           end_before_start,
    input  ready
  );

  modport sink (
    input  valid, elapsed_days, elapsed_hours, elapsed_minutes, elapsed_seconds,
           end_before_start,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/elapsed_time_between_timestamps_top.sv =====
// ----------------------------------------------------------------------------
// elapsed_time_between_timestamps_top: elapsed time between two timestamps
// microcoded day and second difference of two proleptic gregorian timestamps
// ----------------------------------------------------------------------------
// the microprogram runs six steps per timestamp on one shared reciprocal
//   multiplier, two to four day borrow or carry steps, four steps to split the
//   seconds and one to write the word; a new word is taken only once the last
//   step is done, and that step waits while the output register is full
// reset: rst_ni clears the step counter, busy flag and output valid; the block
//   is ready for a word in the first cycle after reset
`default_nettype none

module elapsed_time_between_timestamps_top import etbt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  etbt_in_if.sink  in_i,
  etbt_out_if.source out_o
);

  stamp_t  start_stamp, end_stamp;
  ctrl_t   ctrl;
  status_t status;
  res_t    res;
  logic    load;
  logic    step;
  logic    in_ready;
  logic    out_valid;

  // gather the two timestamps of the input word
  assign start_stamp = '{year: in_i.start_year, month: in_i.start_month,
                         day: in_i.start_day, hour: in_i.start_hour,
                         minute: in_i.start_minute, second: in_i.start_second};
  assign end_stamp   = '{year: in_i.end_year, month: in_i.end_month,
                         day: in_i.end_day, hour: in_i.end_hour,
                         minute: in_i.end_minute, second: in_i.end_second};

  // sequencer walks the program and owns the input handshake
  etbt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .load_o      (load),
    .status_i    (status),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl),
    .step_o      (step)
  );

  // datapath does the arithmetic and holds the output register
  etbt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .start_i     (start_stamp),
    .end_i       (end_stamp),
    .step_i      (step),
    .ctrl_i      (ctrl),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid;
  assign out_o.elapsed_days     = res.days;
  assign out_o.elapsed_hours    = res.hours;
  assign out_o.elapsed_minutes  = res.minutes;
  assign out_o.elapsed_seconds  = res.seconds;
  assign out_o.end_before_start = res.end_before_start;

endmodule

`default_nettype wire

// ===== hw/rtl/etbt_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// etbt_ucode_rom: microprogram store
// one control word per step: datapath operation, jump condition, jump target
// ----------------------------------------------------------------------------
`default_nettype none

module etbt_ucode_rom import etbt_pkg::*; (
  input  logic [PC_W-1:0] pc_i,
  output ctrl_t           ctrl_o
);

  always_comb begin
    unique case (pc_i)
      // one pass per timestamp, start first
      PC_YEAR:    ctrl_o = '{op: OP_YEAR,    jmp: J_NONE,    target: PC_YEAR};
      PC_Q100:    ctrl_o = '{op: OP_Q100,    jmp: J_NONE,    target: PC_YEAR};
      PC_FIX100:  ctrl_o = '{op: OP_FIX100,  jmp: J_NONE,    target: PC_YEAR};
      PC_Q400:    ctrl_o = '{op: OP_Q400,    jmp: J_NONE,    target: PC_YEAR};
      PC_FIX400:  ctrl_o = '{op: OP_FIX400,  jmp: J_NONE,    target: PC_YEAR};
      PC_MONTH:   ctrl_o = '{op: OP_MONTH,   jmp: J_SIDE0,   target: PC_YEAR};
      // borrow and carry between days and seconds
      PC_NORM_LO: ctrl_o = '{op: OP_NORM_LO, jmp: J_SD_NEG,  target: PC_NORM_LO};
      PC_NORM_HI: ctrl_o = '{op: OP_NORM_HI, jmp: J_SD_HIGH, target: PC_NORM_HI};
      // split seconds of day
      PC_HQ:      ctrl_o = '{op: OP_HQ,      jmp: J_NONE,    target: PC_YEAR};
      PC_HFIX:    ctrl_o = '{op: OP_HFIX,    jmp: J_NONE,    target: PC_YEAR};
      PC_MQ:      ctrl_o = '{op: OP_MQ,      jmp: J_NONE,    target: PC_YEAR};
      PC_MFIX:    ctrl_o = '{op: OP_MFIX,    jmp: J_NONE,    target: PC_YEAR};
      default:    ctrl_o = '{op: OP_DONE,    jmp: J_NONE,    target: PC_YEAR};
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/etbt_seq.sv =====
// ----------------------------------------------------------------------------
// etbt_seq: microprogram sequencer
// step counter, conditional jumps and input handshake
// ----------------------------------------------------------------------------
`default_nettype none

module etbt_seq import etbt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    load_o,
  input  status_t status_i,
  input  logic    out_ready_i,
  output ctrl_t   ctrl_o,
  output logic    step_o
);

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            taken;
  logic            stall;
  ctrl_t           ctrl;

  etbt_ucode_rom u_rom (
    .pc_i   (pc_q),
    .ctrl_o (ctrl)
  );

  always_comb begin
    unique case (ctrl.jmp)
      J_NONE:    taken = 1'b0;
      J_SIDE0:   taken = !status_i.side;
      J_SD_NEG:  taken = status_i.sd_neg;
      J_SD_HIGH: taken = status_i.sd_high;
    endcase
  end

  // last step waits while the output register still holds a word that is not taken
  assign stall      = (ctrl.op == OP_DONE) && status_i.out_full && !out_ready_i;
  assign step_o     = busy_q && !stall;
  assign in_ready_o = !busy_q;
  assign load_o     = in_valid_i && !busy_q;
  assign ctrl_o     = ctrl;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (load_o) begin
      busy_d = 1'b1;
      pc_d   = PC_YEAR;
    end else if (step_o) begin
      pc_d = taken ? ctrl.target : pc_q + PC_W'(1);
      if (ctrl.op == OP_DONE) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_YEAR;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |=> busy_q && (pc_q == PC_YEAR))
    else $error("sequencer did not start at the first step");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_o && (ctrl.op == OP_DONE) |=> !busy_q)
    else $error("sequencer still busy after the last step");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= PC_DONE)
    else $error("step counter ran past the program");

endmodule

`default_nettype wire

// ===== hw/rtl/etbt_datapath.sv =====
// ----------------------------------------------------------------------------
// etbt_datapath: working registers and arithmetic of the elapsed time block
// one shared reciprocal multiplier, accumulators and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module etbt_datapath import etbt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  stamp_t  start_i,
  input  stamp_t  end_i,
  input  logic    step_i,
  input  ctrl_t   ctrl_i,
  input  logic    out_ready_i,
  output status_t status_o,
  output logic    out_valid_o,
  output res_t    res_o
);

  stamp_t                   start_q, end_q, cur;
  logic                     side_q, side_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DD_W-1:0]   dd_q, dd_d;
  logic signed [SD_W-1:0]   sd_q, sd_d;
  logic [X_W-1:0]           x_q, x_d;
  logic [Q_W-1:0]           q_q, q_d;
  logic [EHOUR_W-1:0]       hq_q, hq_d;
  logic                     div100_q, div100_d, div400_q, div400_d;
  res_t                     res_q, res_d;

  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_K_W-1:0]       mul_k;
  logic [PROD_W-1:0]        prod;
  logic [REST_W-1:0]        rest;
  logic [REST_W-1:0]        sec_term;
  logic [DD_W-1:0]          yr_term, mon_term;
  logic                     leap;
  logic [DIV_W-1:0]         cdiv;
  logic [X_W-1:0]           cr0, cr_fix;
  logic                     c_hi;
  logic [Q_W-1:0]           cq_fix;
  logic [REST_W-1:0]        hr0, mr0;
  logic                     h_hi, m_hi;

  function automatic logic signed [DD_W-1:0] dd_acc(logic signed [DD_W-1:0] a,
                                                   logic [DD_W-1:0] t, logic neg);
    return neg ? a - $signed(t) : a + $signed(t);
  endfunction

  assign cur  = side_q ? end_q : start_q;
  assign rest = sd_q[REST_W-1:0];

  // terms of one timestamp
  assign yr_term  = DD_W'(cur.year) * DD_W'(365);
  assign sec_term = REST_W'(cur.hour) * REST_W'(3600) + REST_W'(cur.minute) * REST_W'(60)
                  + REST_W'(cur.second);
  assign leap     = (cur.year[1:0] == 2'b00) && (!div100_q || div400_q);
  assign mon_term = DD_W'((X_W'(cur.year) + X_W'(3)) >> 2) + DD_W'(cum_days(cur.month))
                  + DD_W'(leap && (cur.month > MONTH_W'(2))) + DD_W'(cur.day);

  // shared reciprocal multiplier
  always_comb begin
    if ((ctrl_i.op == OP_Q100) || (ctrl_i.op == OP_Q400)) begin
      mul_a = MUL_A_W'(x_q);
      mul_k = RECIP_CENT;
    end else if (ctrl_i.op == OP_HQ) begin
      mul_a = MUL_A_W'(rest);
      mul_k = RECIP_HOUR;
    end else begin
      mul_a = MUL_A_W'(rest);
      mul_k = RECIP_MINUTE;
    end
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_k);

  // quotient correction for the century terms
  assign cdiv   = (ctrl_i.op == OP_FIX400) ? DIV_W'(400) : DIV_W'(100);
  assign cr0    = x_q - X_W'(q_q) * X_W'(cdiv);
  assign c_hi   = cr0 >= X_W'(cdiv);
  assign cr_fix = c_hi ? cr0 - X_W'(cdiv) : cr0;
  assign cq_fix = q_q + Q_W'(c_hi);

  // quotient correction for hours and minutes
  assign hr0  = rest - REST_W'(hq_q) * REST_W'(3600);
  assign h_hi = hr0 >= REST_W'(3600);
  assign mr0  = rest - REST_W'(q_q) * REST_W'(60);
  assign m_hi = mr0 >= REST_W'(60);

  always_comb begin
    side_d   = side_q;
    dd_d     = dd_q;
    sd_d     = sd_q;
    x_d      = x_q;
    q_d      = q_q;
    hq_d     = hq_q;
    div100_d = div100_q;
    div400_d = div400_q;
    res_d    = res_q;
    unique case (ctrl_i.op)
      OP_YEAR: begin
        dd_d = dd_acc(dd_q, yr_term, !side_q);
        sd_d = side_q ? sd_q + $signed(SD_W'(sec_term)) : sd_q - $signed(SD_W'(sec_term));
        x_d  = X_W'(cur.year) + X_W'(99);
      end
      OP_Q100: q_d = Q_W'(prod >> SH_100);
      OP_FIX100: begin
        // the hundreds term counts against the day total
        dd_d     = dd_acc(dd_q, DD_W'(cq_fix), side_q);
        div100_d = cr_fix == X_W'(99);
        x_d      = X_W'(cur.year) + X_W'(399);
      end
      OP_Q400: q_d = Q_W'(prod >> SH_400);
      OP_FIX400: begin
        dd_d     = dd_acc(dd_q, DD_W'(cq_fix), !side_q);
        div400_d = cr_fix == X_W'(399);
      end
      OP_MONTH: begin
        dd_d   = dd_acc(dd_q, mon_term, !side_q);
        side_d = !side_q;
      end
      OP_NORM_LO: begin
        if (sd_q[SD_W-1]) begin
          sd_d = sd_q + SECS_DAY;
          dd_d = dd_q - DD_W'(1);
        end
      end
      OP_NORM_HI: begin
        if (!sd_q[SD_W-1] && (sd_q >= SECS_DAY)) begin
          sd_d = sd_q - SECS_DAY;
          dd_d = dd_q + DD_W'(1);
        end
      end
      OP_HQ: hq_d = EHOUR_W'(prod >> SH_HOUR);
      OP_HFIX: begin
        hq_d = hq_q + EHOUR_W'(h_hi);
        sd_d = $signed(SD_W'(h_hi ? hr0 - REST_W'(3600) : hr0));
      end
      OP_MQ: q_d = Q_W'(prod >> SH_MINUTE);
      OP_MFIX: begin
        q_d  = q_q + Q_W'(m_hi);
        sd_d = $signed(SD_W'(m_hi ? mr0 - REST_W'(60) : mr0));
      end
      OP_DONE: begin
        if (dd_q[DD_W-1]) begin
          res_d = '{days: '0, hours: '0, minutes: '0, seconds: '0, end_before_start: 1'b1};
        end else if (dd_q > DAYS_MAX) begin
          res_d = '{days: '1, hours: EHOUR_W'(23), minutes: EMIN_W'(59),
                    seconds: ESEC_W'(59), end_before_start: 1'b0};
        end else begin
          res_d = '{days: dd_q[EDAYS_W-1:0], hours: hq_q, minutes: q_q[EMIN_W-1:0],
                    seconds: sd_q[ESEC_W-1:0], end_before_start: 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (step_i && (ctrl_i.op == OP_DONE)) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load_i) begin
        side_q <= 1'b0;
      end else if (step_i) begin
        side_q <= side_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      start_q <= start_i;
      end_q   <= end_i;
      dd_q    <= '0;
      sd_q    <= '0;
    end else if (step_i) begin
      dd_q     <= dd_d;
      sd_q     <= sd_d;
      x_q      <= x_d;
      q_q      <= q_d;
      hq_q     <= hq_d;
      div100_q <= div100_d;
      div400_q <= div400_d;
      res_q    <= res_d;
    end
  end

  assign status_o = '{side: side_q, sd_neg: sd_q[SD_W-1],
                      sd_high: !sd_q[SD_W-1] && (sd_q >= SECS_DAY), out_full: out_valid_q};
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_rest_in_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (ctrl_i.op == OP_HQ) |-> !sd_q[SD_W-1] && (sd_q < SECS_DAY))
    else $error("seconds of day not normalized before the split");

  a_rest_in_hour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (ctrl_i.op == OP_HFIX) |=> !sd_q[SD_W-1] && (sd_q < SECS_HOUR))
    else $error("hour quotient correction left a remainder of an hour or more");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.end_before_start |->
      (res_q.days == '0) && (res_q.hours == '0) && (res_q.minutes == '0)
      && (res_q.seconds == '0))
    else $error("reversed span with nonzero elapsed fields");

endmodule

`default_nettype wire
